/* src/assert_macros.svh */
// assertion macros used by the core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, expr)

`define ASSERT_IMPLIES(label, ante, cons)

`endif

`endif

/* src/kpdc_pkg.sv */
// shared types and constants for the key press duration classifier
package kpdc_pkg;

    localparam int CFG_WIDTH = 16;
    localparam int CFG_ADDR_WIDTH = 3;

    localparam logic [CFG_ADDR_WIDTH-1:0] REG_SHORT_INTERVAL  = 3'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_MEDIUM_INTERVAL = 3'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_DEBOUNCE_TICKS  = 3'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_REPEAT_TICKS    = 3'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_REPEAT_ENABLE   = 3'd4;

    localparam logic [CFG_WIDTH-1:0] RST_SHORT_INTERVAL  = 16'd400;
    localparam logic [CFG_WIDTH-1:0] RST_MEDIUM_INTERVAL = 16'd1000;
    localparam logic [CFG_WIDTH-1:0] RST_DEBOUNCE_TICKS  = 16'd10;
    localparam logic [CFG_WIDTH-1:0] RST_REPEAT_TICKS    = 16'd200;

    localparam logic [1:0] PH_RELEASED = 2'd0;
    localparam logic [1:0] PH_PRESSED  = 2'd1;
    localparam logic [1:0] PH_DEBOUNCE = 2'd2;

    localparam logic [1:0] CL_SHORT  = 2'd0;
    localparam logic [1:0] CL_MEDIUM = 2'd1;
    localparam logic [1:0] CL_LONG   = 2'd2;

    localparam logic [1:0] KEY_NONE = 2'd0;
    localparam logic [1:0] KEY_1    = 2'd1;
    localparam logic [1:0] KEY_2    = 2'd2;
    localparam logic [1:0] KEY_3    = 2'd3;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] short_interval;
        logic [CFG_WIDTH-1:0] medium_interval;
        logic [CFG_WIDTH-1:0] debounce_ticks;
        logic [CFG_WIDTH-1:0] repeat_ticks;
        logic                 repeat_enable;
    } kpdc_cfg_t;

    typedef struct packed {
        logic       is_repeat;
        logic [1:0] press_class;
        logic [1:0] key_code;
        logic       event_res;
    } kpdc_result_t;

endpackage

/* src/key_press_duration_classifier_core.sv */
// top level of the key press duration classifier
//
// one input beat on s_axis is one tick carrying the three button levels
// (bit 0 is button 1). every tick gives exactly one output beat on m_axis
// with event_res, key_code, press_class and is_repeat; event_res is 0 on
// ticks without a key report.
// the beat is taken into an input register, the tick update runs as
// combinational logic from there into the output register: output valid
// rises when the output register takes the beat over, and one beat is accepted
// per cycle as long as the output side takes one per cycle.
// when m_tready is low the output register holds its beat; the input
// register still takes one more beat, then s_tready drops until the output
// side moves again. no beat is lost or repeated.
// the configuration port writes one register per cycle at cfg_wr_en:
// 0 short_interval, 1 medium_interval, 2 debounce_ticks, 3 repeat_ticks,
// 4 repeat_enable; other indexes are ignored. write only while idle.
// reset puts the registers to 400, 1000, 10, 200, 1, releases the key,
// clears both timers and empties both stages.
`include "assert_macros.svh"

module key_press_duration_classifier_core #(
    parameter int TIMER_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // [2:0] buttons
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,  // [0] event_res, [2:1] key_code,
                                                          // [4:3] press_class, [5] is_repeat
    input  logic                                cfg_wr_en,
    input  logic [kpdc_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [kpdc_pkg::CFG_WIDTH-1:0]      cfg_wdata
);
    import kpdc_pkg::*;

    kpdc_cfg_t    cfg;
    kpdc_result_t step_result;

    logic         in_valid_reg;
    logic [2:0]   in_buttons_reg;
    logic         out_valid_reg;
    kpdc_result_t out_data_reg;
    logic         advance;
    logic         in_accept;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;

    kpdc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    kpdc_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .buttons (in_buttons_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_buttons_reg <= s_tdata[2:0];
        if (advance)
            out_data_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg.is_repeat, out_data_reg.press_class,
                       out_data_reg.key_code, out_data_reg.event_res};

    // no report means all result fields are zero
    `ASSERT_IMPLIES(a_quiet_beat, out_valid_reg && !out_data_reg.event_res,
                    out_data_reg.key_code == KEY_NONE && out_data_reg.press_class == CL_SHORT &&
                    !out_data_reg.is_repeat)
    // a report always names a key
    `ASSERT_IMPLIES(a_event_has_key, out_valid_reg && out_data_reg.event_res,
                    out_data_reg.key_code != KEY_NONE)
    // repeats only come from a long press
    `ASSERT_IMPLIES(a_repeat_is_long, out_valid_reg && out_data_reg.is_repeat,
                    out_data_reg.event_res && out_data_reg.press_class == CL_LONG)
    // an empty input stage always takes a beat
    `ASSERT_IMPLIES(a_empty_ready, !in_valid_reg, s_tready)

endmodule

/* src/kpdc_cfg_regs.sv */
// configuration register bank
module kpdc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [kpdc_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [kpdc_pkg::CFG_WIDTH-1:0]      cfg_wdata,
    output kpdc_pkg::kpdc_cfg_t                 cfg
);
    import kpdc_pkg::*;

    kpdc_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_interval  <= RST_SHORT_INTERVAL;
            cfg_reg.medium_interval <= RST_MEDIUM_INTERVAL;
            cfg_reg.debounce_ticks  <= RST_DEBOUNCE_TICKS;
            cfg_reg.repeat_ticks    <= RST_REPEAT_TICKS;
            cfg_reg.repeat_enable   <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_SHORT_INTERVAL:  cfg_reg.short_interval  <= cfg_wdata;
                REG_MEDIUM_INTERVAL: cfg_reg.medium_interval <= cfg_wdata;
                REG_DEBOUNCE_TICKS:  cfg_reg.debounce_ticks  <= cfg_wdata;
                REG_REPEAT_TICKS:    cfg_reg.repeat_ticks    <= cfg_wdata;
                REG_REPEAT_ENABLE:   cfg_reg.repeat_enable   <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/kpdc_step.sv */
// key state, timers and per-tick classification
module kpdc_step #(
    parameter int TIMER_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step_en,
    input  logic [2:0]             buttons,
    input  kpdc_pkg::kpdc_cfg_t    cfg,
    output kpdc_pkg::kpdc_result_t result
);
    import kpdc_pkg::*;

    logic [1:0]            phase_reg, phase_next;
    logic [1:0]            class_reg, class_next;
    logic [1:0]            held_key_reg, held_key_next;
    logic [TIMER_BITS-1:0] press_timer_reg, press_timer_next;
    logic [TIMER_BITS-1:0] repeat_timer_reg, repeat_timer_next;

    logic [1:0]            key;
    logic [TIMER_BITS-1:0] press_dec;
    logic [TIMER_BITS-1:0] repeat_dec;
    logic                  repeat_fire;
    kpdc_result_t          res;

    always_comb
    begin
        if (buttons[0])
            key = KEY_1;
        else if (buttons[1])
            key = KEY_2;
        else if (buttons[2])
            key = KEY_3;
        else
            key = KEY_NONE;
    end

    always_comb
    begin
        press_dec  = (press_timer_reg == '0) ? '0 : press_timer_reg - 1'b1;
        repeat_dec = (repeat_timer_reg == '0) ? '0 : repeat_timer_reg - 1'b1;

        phase_next    = phase_reg;
        class_next    = class_reg;
        held_key_next = held_key_reg;
        press_timer_next = press_dec;

        res = '0;

        // repeat while held long
        repeat_fire = (phase_reg == PH_PRESSED) && (class_reg == CL_LONG) &&
                      cfg.repeat_enable && (repeat_dec == '0);
        repeat_timer_next = repeat_fire ? TIMER_BITS'(cfg.repeat_ticks) : repeat_dec;
        if (repeat_fire)
        begin
            res.event_res   = 1'b1;
            res.key_code    = held_key_reg;
            res.press_class = CL_LONG;
            res.is_repeat   = 1'b1;
        end

        if (key != KEY_NONE)
        begin
            if (phase_reg == PH_RELEASED)
            begin
                held_key_next    = key;
                phase_next       = PH_PRESSED;
                class_next       = CL_SHORT;
                press_timer_next = TIMER_BITS'(cfg.short_interval);
            end
            else if (phase_reg == PH_PRESSED)
            begin
                if (press_dec == '0 && class_reg == CL_SHORT)
                begin
                    class_next       = CL_MEDIUM;
                    press_timer_next = TIMER_BITS'(cfg.medium_interval);
                end
                if (press_timer_next == '0 && class_next == CL_MEDIUM)
                    class_next = CL_LONG;
            end
        end
        else if (phase_reg == PH_PRESSED)
        begin
            phase_next       = PH_DEBOUNCE;
            press_timer_next = TIMER_BITS'(cfg.debounce_ticks);
        end

        // debounce done, report the release
        if (phase_next == PH_DEBOUNCE && press_timer_next == '0)
        begin
            res.event_res   = 1'b1;
            res.key_code    = held_key_next;
            res.press_class = class_next;
            res.is_repeat   = 1'b0;
            phase_next      = PH_RELEASED;
            held_key_next   = KEY_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_RELEASED;
            class_reg        <= CL_SHORT;
            held_key_reg     <= KEY_NONE;
            press_timer_reg  <= '0;
            repeat_timer_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg        <= phase_next;
            class_reg        <= class_next;
            held_key_reg     <= held_key_next;
            press_timer_reg  <= press_timer_next;
            repeat_timer_reg <= repeat_timer_next;
        end
    end

    assign result = res;

endmodule

/* tb/key_press_duration_classifier_core_test.sv */
// self-checking testbench for the key press duration classifier core
module key_press_duration_classifier_core_test;
    import kpdc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS = 210;
    localparam int SCRIPT_ROWS = 31;
    localparam logic [CFG_ADDR_WIDTH-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic                      is_cfg;
        logic [CFG_ADDR_WIDTH-1:0] addr;
        logic [CFG_WIDTH-1:0]      wdata;
        logic [2:0]                buttons;
        logic                      typed;
        kpdc_result_t              want;
    } script_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [7:0]                s_tdata;   // [2:0] buttons
    logic                      m_tvalid;
    logic                      m_tready;
    logic [7:0]                m_tdata;   // [0] event_res, [2:1] key_code,
                                          // [4:3] press_class, [5] is_repeat
    logic                      cfg_wr_en;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr;
    logic [CFG_WIDTH-1:0]      cfg_wdata;

    // shadow registers and classifier state
    logic [15:0] short_ivl;
    logic [15:0] medium_ivl;
    logic [15:0] debounce_len;
    logic [15:0] repeat_len;
    logic        repeat_on;
    logic [1:0]  kp_phase;
    logic [1:0]  press_cls;
    logic [1:0]  held;
    logic [15:0] press_left;
    logic [15:0] repeat_left;

    kpdc_result_t reports_due[$];
    script_row_t  script [SCRIPT_ROWS];
    int           mismatches = 0;
    int           cycles = 0;
    int           ticks_sent = 0;
    int           stall_left = 0;
    logic         tx_steady;
    logic         rx_steady;

    key_press_duration_classifier_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic kpdc_result_t classify_tick(logic [2:0] buttons);
        kpdc_result_t r;
        logic [1:0]   k;
        r = '0;
        k = buttons[0] ? KEY_1 : buttons[1] ? KEY_2 : buttons[2] ? KEY_3 : KEY_NONE;
        if (press_left != 0) press_left = press_left - 1'b1;
        if (repeat_left != 0) repeat_left = repeat_left - 1'b1;
        if (kp_phase == PH_PRESSED && press_cls == CL_LONG && repeat_on && repeat_left == 0)
        begin
            r = '{is_repeat: 1'b1, press_class: CL_LONG, key_code: held, event_res: 1'b1};
            repeat_left = repeat_len;
        end
        if (k != KEY_NONE)
        begin
            if (kp_phase == PH_RELEASED)
            begin
                held = k;
                kp_phase = PH_PRESSED;
                press_cls = CL_SHORT;
                press_left = short_ivl;
            end
            else if (kp_phase == PH_PRESSED)
            begin
                if (press_left == 0 && press_cls == CL_SHORT)
                begin
                    press_cls = CL_MEDIUM;
                    press_left = medium_ivl;
                end
                if (press_left == 0 && press_cls == CL_MEDIUM)
                    press_cls = CL_LONG;
            end
        end
        else if (kp_phase == PH_PRESSED)
        begin
            kp_phase = PH_DEBOUNCE;
            press_left = debounce_len;
        end
        // release report wins over a repeat in the same tick
        if (kp_phase == PH_DEBOUNCE && press_left == 0)
        begin
            r = '{is_repeat: 1'b0, press_class: press_cls, key_code: held, event_res: 1'b1};
            kp_phase = PH_RELEASED;
            held = KEY_NONE;
        end
        return r;
    endfunction

    function automatic script_row_t cfg_row(logic [CFG_ADDR_WIDTH-1:0] a,
                                            logic [CFG_WIDTH-1:0] d);
        script_row_t row;
        row = '0;
        row.is_cfg = 1'b1;
        row.addr = a;
        row.wdata = d;
        return row;
    endfunction

    function automatic script_row_t tick_row(logic [2:0] b);
        script_row_t row;
        row = '0;
        row.buttons = b;
        return row;
    endfunction

    function automatic script_row_t checked_row(logic [2:0] b, logic ev, logic [1:0] key,
                                                logic [1:0] cls, logic rep);
        script_row_t row;
        row = '0;
        row.buttons = b;
        row.typed = 1'b1;
        row.want = '{is_repeat: rep, press_class: cls, key_code: key, event_res: ev};
        return row;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic drain();
        @(negedge clk) s_tvalid <= 1'b0;
        while (reports_due.size() != 0) @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] idx,
                             input logic [CFG_WIDTH-1:0] val);
        drain();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_SHORT_INTERVAL:  short_ivl = val;
            REG_MEDIUM_INTERVAL: medium_ivl = val;
            REG_DEBOUNCE_TICKS:  debounce_len = val;
            REG_REPEAT_TICKS:    repeat_len = val;
            REG_REPEAT_ENABLE:   repeat_on = val[0];
            default: ;
        endcase
        @(negedge clk) cfg_wr_en <= 1'b0;
    endtask

    task automatic send_tick(input logic [2:0] buttons, input logic typed = 1'b0,
                             input kpdc_result_t want = '0);
        int           gap;
        kpdc_result_t r;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk) s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, buttons};
        do @(posedge clk); while (!s_tready);
        r = classify_tick(buttons);
        reports_due.push_back(typed ? want : r);
        ticks_sent++;
    endtask

    // output side back-pressure
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        kpdc_result_t got;
        kpdc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[5:0];
            if (reports_due.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got %h", $time, m_tdata);
                mismatches++;
            end
            else
            begin
                want = reports_due.pop_front();
                if (got.event_res !== want.event_res || got.key_code !== want.key_code ||
                    got.press_class !== want.press_class ||
                    got.is_repeat !== want.is_repeat || m_tdata[7:6] !== 2'b00)
                begin
                    $display("%0t: expected ev=%0d key=%0d class=%0d rep=%0d, got %h",
                             $time, want.event_res, want.key_code, want.press_class,
                             want.is_repeat, m_tdata);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] s, m, d, r;
        logic        en;
        int          phase_start;
        int          hold;
        int          hold_max;
        int          tail_max;
        logic        first_seq;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        short_ivl = RST_SHORT_INTERVAL;
        medium_ivl = RST_MEDIUM_INTERVAL;
        debounce_len = RST_DEBOUNCE_TICKS;
        repeat_len = RST_REPEAT_TICKS;
        repeat_on = 1'b1;
        kp_phase = PH_RELEASED;
        press_cls = CL_SHORT;
        held = KEY_NONE;
        press_left = '0;
        repeat_left = '0;
        repeat (6) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed: chaining, repeats, release with repeat, key during debounce
        script = '{
            cfg_row(REG_SHORT_INTERVAL, 16'd2),
            cfg_row(REG_MEDIUM_INTERVAL, 16'd0),
            cfg_row(REG_DEBOUNCE_TICKS, 16'd0),
            cfg_row(REG_REPEAT_TICKS, 16'd1),
            cfg_row(REG_REPEAT_ENABLE, 16'd1),
            checked_row(3'b000, 1'b0, KEY_NONE, CL_SHORT, 1'b0),
            tick_row(3'b111),
            tick_row(3'b110),
            tick_row(3'b100),
            checked_row(3'b001, 1'b1, KEY_1, CL_LONG, 1'b1),
            tick_row(3'b001),
            checked_row(3'b000, 1'b1, KEY_1, CL_LONG, 1'b0),
            tick_row(3'b000),
            cfg_row(REG_DEBOUNCE_TICKS, 16'd3),
            cfg_row(REG_SHORT_INTERVAL, 16'd0),
            cfg_row(REG_MEDIUM_INTERVAL, 16'd1),
            tick_row(3'b010),
            tick_row(3'b010),
            tick_row(3'b010),
            tick_row(3'b000),
            tick_row(3'b100),
            tick_row(3'b111),
            tick_row(3'b000),
            cfg_row(REG_REPEAT_ENABLE, 16'hFFFE),
            cfg_row(REG_UNUSED, 16'hFFFF),
            cfg_row(REG_SHORT_INTERVAL, 16'hFFFF),
            tick_row(3'b100),
            tick_row(3'b000),
            tick_row(3'b000),
            tick_row(3'b000),
            checked_row(3'b000, 1'b1, KEY_3, CL_SHORT, 1'b0)
        };
        foreach (script[i])
        begin
            if (script[i].is_cfg)
                write_reg(script[i].addr, script[i].wdata);
            else
                send_tick(script[i].buttons, script[i].typed, script[i].want);
        end

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    s = RST_SHORT_INTERVAL;
                    m = RST_MEDIUM_INTERVAL;
                    d = RST_DEBOUNCE_TICKS;
                    r = RST_REPEAT_TICKS;
                    en = 1'b1;
                end
                1:
                begin
                    s = '0;
                    m = '0;
                    d = '0;
                    r = '0;
                    en = 1'b1;
                end
                2:
                begin
                    s = 16'hFFFF;
                    m = 16'hFFFF;
                    d = 16'($urandom_range(0, 5));
                    r = 16'hFFFF;
                    en = 1'b1;
                end
                RANDOM_PHASES - 1:
                begin
                    s = 16'hFFFF;
                    m = 16'hFFFF;
                    d = 16'hFFFF;
                    r = 16'hFFFF;
                    en = 1'b1;
                end
                default:
                begin
                    s = 16'($urandom_range(0, 12));
                    m = 16'($urandom_range(0, 12));
                    d = 16'($urandom_range(0, 8));
                    r = 16'($urandom_range(0, 6));
                    en = 1'($urandom_range(0, 1));
                end
            endcase
            write_reg(REG_SHORT_INTERVAL, s);
            write_reg(REG_MEDIUM_INTERVAL, m);
            write_reg(REG_DEBOUNCE_TICKS, d);
            write_reg(REG_REPEAT_TICKS, r);
            write_reg(REG_REPEAT_ENABLE, {15'($urandom), en});
            write_reg(CFG_ADDR_WIDTH'($urandom_range(5, 7)), CFG_WIDTH'($urandom));
            tx_steady = (ph % 3 == 1);
            rx_steady = (ph % 3 == 2);
            hold_max = int'(s) + int'(m) + 3 * int'(r) + 6;
            if (hold_max > 48) hold_max = 48;
            tail_max = int'(d) + 3;
            if (tail_max > 24) tail_max = 24;
            phase_start = ticks_sent;
            first_seq = 1'b1;
            while (ticks_sent - phase_start < PHASE_TICKS)
            begin
                if (!first_seq && $urandom_range(0, 7) == 0)
                begin
                    // noise
                    repeat ($urandom_range(1, 5)) send_tick(3'($urandom_range(0, 7)));
                end
                else
                begin
                    hold = (ph == 0 && first_seq) ? $urandom_range(410, 470)
                                                  : $urandom_range(1, hold_max);
                    repeat (hold) send_tick(3'($urandom_range(1, 7)));
                    send_tick(3'b000);
                    repeat ($urandom_range(0, tail_max))
                        send_tick(($urandom_range(0, 4) == 0) ? 3'($urandom_range(1, 7))
                                                              : 3'b000);
                end
                first_seq = 1'b0;
                if ($urandom_range(0, 29) == 0) drain();
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/kpdc_pkg.sv
src/kpdc_cfg_regs.sv
src/kpdc_step.sv
src/key_press_duration_classifier_core.sv
tb/key_press_duration_classifier_core_test.sv
